// File: sv/json_token_lexer_macros.svh
// Assertion macros shared by the JSON token lexer RTL.
`ifndef JSON_TOKEN_LEXER_MACROS_SVH
`define JSON_TOKEN_LEXER_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define JTL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define JTL_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/jtl_pkg.sv
// Shared types and constants of the JSON token lexer.
package jtl_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned ERR_W   = 2;

  // Depth of the result queue; a step fires only when two entries are free.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_LBRACKET = 4'd0;
  localparam logic [KIND_W-1:0] KIND_RBRACKET = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LBRACE   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RBRACE   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_COMMA    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_COLON    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_STRING   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_TRUE     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_FALSE    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_NULL     = 4'd9;
  localparam logic [KIND_W-1:0] KIND_POS_INT  = 4'd10;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [ERR_W-1:0] ERR_STRING  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_KEYWORD = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [CHAR_W-1:0] lexeme_char;
    logic              char_valid;
    logic              token_done;
    logic [ERR_W-1:0]  error_code;
    logic              run_last;
  } jtl_res_t;

endpackage

// File: sv/jtl_if.sv
// Request channels of the JSON token lexer: text bytes in, token results out.
interface jtl_in_if;
  logic                          valid;
  logic                          ready;
  logic [jtl_pkg::CHAR_W-1:0]    text_byte;
  logic                          final_byte;

  modport source (output valid, text_byte, final_byte, input ready);
  modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

interface jtl_out_if;
  logic                          valid;
  logic                          ready;
  logic [jtl_pkg::KIND_W-1:0]    token_kind;
  logic [jtl_pkg::CHAR_W-1:0]    lexeme_char;
  logic                          char_valid;
  logic                          token_done;
  logic [jtl_pkg::ERR_W-1:0]     error_code;
  logic                          run_last;

  modport source (output valid, token_kind, lexeme_char, char_valid, token_done, error_code,
                  run_last, input ready);
  modport sink   (input valid, token_kind, lexeme_char, char_valid, token_done, error_code,
                  run_last, output ready);
endinterface

// File: sv/jtl_lex_core.sv
// Lexer state registers and the per-byte next-state and result logic.
module jtl_lex_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [jtl_pkg::CHAR_W-1:0] char_i,
  input  logic                       fin_i,
  output logic [1:0]                 res_cnt_o,
  output jtl_pkg::jtl_res_t          res0_o,
  output jtl_pkg::jtl_res_t          res1_o
);

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_STRING  = 5'b00010,
    MODE_KEYWORD = 5'b00100,
    MODE_INT     = 5'b01000,
    MODE_FRAC    = 5'b10000
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [1:0]        sel;
    logic [2:0]        pos;
    logic              neg;
    logic [jtl_pkg::ERR_W-1:0] err;
    logic              emit;
    jtl_pkg::jtl_res_t res;
  } start_t;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6E;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  mode_e                      mode_q, mode_d;
  logic [1:0]                 kw_sel_q, kw_sel_d;
  logic [2:0]                 kw_pos_q, kw_pos_d;
  logic                       neg_q, neg_d;
  logic [jtl_pkg::ERR_W-1:0]  err_q, err_d;
  start_t                     start;
  logic [1:0]                 cnt;
  jtl_pkg::jtl_res_t          r0, r1;
  logic                       is_digit;
  logic                       frac_now;
  logic                       frac_next;
  logic [2:0]                 kw_len;
  logic [2:0]                 kw_pos_inc;
  logic [7:0]                 kw_chr;
  logic [jtl_pkg::KIND_W-1:0] kw_kind;

  function automatic logic [jtl_pkg::KIND_W-1:0] num_kind(input logic neg, input logic frac);
    num_kind = jtl_pkg::KIND_POS_INT + {2'b00, frac, 1'b0} + {3'b000, neg};
  endfunction

  function automatic jtl_pkg::jtl_res_t err_res(input logic [jtl_pkg::ERR_W-1:0] code);
    jtl_pkg::jtl_res_t r;
    r            = '0;
    r.error_code = code;
    return r;
  endfunction

  function automatic jtl_pkg::jtl_res_t tok_res(input logic [jtl_pkg::KIND_W-1:0] kind,
                                                input logic [7:0] ch, input logic valid,
                                                input logic done);
    jtl_pkg::jtl_res_t r;
    r             = '0;
    r.token_kind  = kind;
    r.lexeme_char = ch;
    r.char_valid  = valid;
    r.token_done  = done;
    return r;
  endfunction

  // Handling of a byte seen outside any token; also used for the byte that ends a number.
  function automatic start_t start_byte(input logic [7:0] c, input logic fin,
                                        input logic [1:0] sel, input logic [2:0] pos,
                                        input logic neg);
    start_t s;
    s.mode = MODE_IDLE;
    s.sel  = sel;
    s.pos  = pos;
    s.neg  = neg;
    s.err  = jtl_pkg::ERR_NONE;
    s.emit = 1'b1;
    s.res  = '0;
    if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR)) begin
      s.emit = 1'b0;
    end else if (c == CH_LBRACKET) begin
      s.res = tok_res(jtl_pkg::KIND_LBRACKET, '0, 1'b0, 1'b1);
    end else if (c == CH_RBRACKET) begin
      s.res = tok_res(jtl_pkg::KIND_RBRACKET, '0, 1'b0, 1'b1);
    end else if (c == CH_LBRACE) begin
      s.res = tok_res(jtl_pkg::KIND_LBRACE, '0, 1'b0, 1'b1);
    end else if (c == CH_RBRACE) begin
      s.res = tok_res(jtl_pkg::KIND_RBRACE, '0, 1'b0, 1'b1);
    end else if (c == CH_COMMA) begin
      s.res = tok_res(jtl_pkg::KIND_COMMA, '0, 1'b0, 1'b1);
    end else if (c == CH_COLON) begin
      s.res = tok_res(jtl_pkg::KIND_COLON, '0, 1'b0, 1'b1);
    end else if (c == CH_QUOTE) begin
      if (fin) begin
        s.err = jtl_pkg::ERR_STRING;
        s.res = err_res(jtl_pkg::ERR_STRING);
      end else begin
        s.mode = MODE_STRING;
        s.emit = 1'b0;
      end
    end else if ((c == CH_T) || (c == CH_F) || (c == CH_N)) begin
      if (fin) begin
        s.err = jtl_pkg::ERR_KEYWORD;
        s.res = err_res(jtl_pkg::ERR_KEYWORD);
      end else begin
        s.sel  = (c == CH_T) ? KW_TRUE : ((c == CH_F) ? KW_FALSE : KW_NULL);
        s.pos  = 3'd1;
        s.mode = MODE_KEYWORD;
        s.emit = 1'b0;
      end
    end else if ((c == CH_MINUS) || ((c >= CH_ZERO) && (c <= CH_NINE))) begin
      s.neg  = (c == CH_MINUS);
      s.mode = fin ? MODE_IDLE : MODE_INT;
      s.res  = tok_res(num_kind(c == CH_MINUS, 1'b0), c, 1'b1, fin);
    end else begin
      s.err = jtl_pkg::ERR_UNKNOWN;
      s.res = err_res(jtl_pkg::ERR_UNKNOWN);
    end
    return s;
  endfunction

  // Keyword spelling tables; select code 3 behaves as null.
  always_comb begin
    unique case (kw_sel_q)
      KW_TRUE: begin
        kw_len  = 3'd4;
        kw_kind = jtl_pkg::KIND_TRUE;
        unique case (kw_pos_q)
          3'd0:    kw_chr = 8'h74;
          3'd1:    kw_chr = 8'h72;
          3'd2:    kw_chr = 8'h75;
          3'd3:    kw_chr = 8'h65;
          default: kw_chr = 8'h00;
        endcase
      end
      KW_FALSE: begin
        kw_len  = 3'd5;
        kw_kind = jtl_pkg::KIND_FALSE;
        unique case (kw_pos_q)
          3'd0:    kw_chr = 8'h66;
          3'd1:    kw_chr = 8'h61;
          3'd2:    kw_chr = 8'h6C;
          3'd3:    kw_chr = 8'h73;
          3'd4:    kw_chr = 8'h65;
          default: kw_chr = 8'h00;
        endcase
      end
      default: begin
        kw_len  = 3'd4;
        kw_kind = jtl_pkg::KIND_NULL;
        unique case (kw_pos_q)
          3'd0:    kw_chr = 8'h6E;
          3'd1:    kw_chr = 8'h75;
          3'd2:    kw_chr = 8'h6C;
          3'd3:    kw_chr = 8'h6C;
          default: kw_chr = 8'h00;
        endcase
      end
    endcase
  end

  assign kw_pos_inc = kw_pos_q + 3'd1;
  assign is_digit   = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign frac_now   = (mode_q == MODE_FRAC);
  assign frac_next  = frac_now || (char_i == CH_DOT);
  assign start      = start_byte(char_i, fin_i, kw_sel_q, kw_pos_q, neg_q);

  always_comb begin
    mode_d   = mode_q;
    kw_sel_d = kw_sel_q;
    kw_pos_d = kw_pos_q;
    neg_d    = neg_q;
    err_d    = err_q;
    cnt      = 2'd0;
    r0       = '0;
    r1       = '0;
    if (err_q != jtl_pkg::ERR_NONE) begin
      cnt = 2'd1;
      r0  = err_res(err_q);
    end else begin
      unique case (mode_q)
        MODE_STRING: begin
          cnt = 2'd1;
          if (char_i == CH_QUOTE) begin
            mode_d = MODE_IDLE;
            r0     = tok_res(jtl_pkg::KIND_STRING, '0, 1'b0, 1'b1);
          end else if (fin_i) begin
            mode_d = MODE_IDLE;
            err_d  = jtl_pkg::ERR_STRING;
            r0     = err_res(jtl_pkg::ERR_STRING);
          end else begin
            r0 = tok_res(jtl_pkg::KIND_STRING, char_i, 1'b1, 1'b0);
          end
        end
        MODE_KEYWORD: begin
          if ((kw_pos_q >= kw_len) || (char_i != kw_chr)) begin
            cnt    = 2'd1;
            mode_d = MODE_IDLE;
            err_d  = jtl_pkg::ERR_KEYWORD;
            r0     = err_res(jtl_pkg::ERR_KEYWORD);
          end else begin
            kw_pos_d = kw_pos_inc;
            if (kw_pos_inc == kw_len) begin
              cnt    = 2'd1;
              mode_d = MODE_IDLE;
              r0     = tok_res(kw_kind, '0, 1'b0, 1'b1);
            end else if (fin_i) begin
              // Text ended with the keyword only partly spelled.
              cnt    = 2'd1;
              mode_d = MODE_IDLE;
              err_d  = jtl_pkg::ERR_KEYWORD;
              r0     = err_res(jtl_pkg::ERR_KEYWORD);
            end
          end
        end
        MODE_INT, MODE_FRAC: begin
          if (is_digit || ((char_i == CH_DOT) && !frac_now)) begin
            cnt    = 2'd1;
            mode_d = fin_i ? MODE_IDLE : (frac_next ? MODE_FRAC : MODE_INT);
            r0     = tok_res(num_kind(neg_q, frac_next), char_i, 1'b1, fin_i);
          end else begin
            // The number closes, then the same byte is lexed from idle.
            r0       = tok_res(num_kind(neg_q, frac_now), '0, 1'b0, 1'b1);
            r1       = start.res;
            cnt      = start.emit ? 2'd2 : 2'd1;
            mode_d   = start.mode;
            kw_sel_d = start.sel;
            kw_pos_d = start.pos;
            neg_d    = start.neg;
            err_d    = start.err;
          end
        end
        default: begin
          r0       = start.res;
          cnt      = start.emit ? 2'd1 : 2'd0;
          mode_d   = start.mode;
          kw_sel_d = start.sel;
          kw_pos_d = start.pos;
          neg_d    = start.neg;
          err_d    = start.err;
        end
      endcase
    end
    r0.run_last = (cnt == 2'd1);
    r1.run_last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      kw_sel_q <= '0;
      kw_pos_q <= '0;
      neg_q    <= 1'b0;
      err_q    <= jtl_pkg::ERR_NONE;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      kw_sel_q <= kw_sel_d;
      kw_pos_q <= kw_pos_d;
      neg_q    <= neg_d;
      err_q    <= err_d;
    end
  end

  assign res_cnt_o = cnt;
  assign res0_o    = r0;
  assign res1_o    = r1;

endmodule

// File: sv/jtl_res_fifo.sv
// Result queue that takes up to two results per cycle and gives one.
module jtl_res_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          push_cnt_i,
  input  jtl_pkg::jtl_res_t                   push0_i,
  input  jtl_pkg::jtl_res_t                   push1_i,
  input  logic                                pop_i,
  output jtl_pkg::jtl_res_t                   head_o,
  output logic                                valid_o,
  output logic                                room_o,
  output logic [jtl_pkg::RES_CNT_W-1:0]       count_o
);

  jtl_pkg::jtl_res_t                  mem_q [jtl_pkg::RES_DEPTH];
  logic [jtl_pkg::RES_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [jtl_pkg::RES_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [jtl_pkg::RES_CNT_W-1:0]      cnt_q, cnt_d;
  logic [jtl_pkg::RES_PTR_W-1:0]      wr_ptr_nxt;
  logic                               pop;

  assign pop        = pop_i && (cnt_q != '0);
  assign wr_ptr_nxt = wr_ptr_q + jtl_pkg::RES_PTR_W'(1);
  assign wr_ptr_d   = wr_ptr_q + jtl_pkg::RES_PTR_W'(push_cnt_i);
  assign rd_ptr_d   = rd_ptr_q + jtl_pkg::RES_PTR_W'(pop);
  assign cnt_d      = cnt_q + jtl_pkg::RES_CNT_W'(push_cnt_i) - jtl_pkg::RES_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push1_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= jtl_pkg::RES_CNT_W'(jtl_pkg::RES_DEPTH - 2));
  assign count_o = cnt_q;

endmodule

// File: sv/json_token_lexer.sv
// A taken byte is held in a register and lexed once the four-entry result queue has room
// for two results; the results are written into the queue and offered on the output.
// Throughput: one byte per cycle while each byte gives at most one result and the output is
// ready; a byte that closes a number and starts another token gives two, and the queue
// drains one per cycle. Reset clears the lexer to idle with no error, and empties the queue.
`include "json_token_lexer_macros.svh"

module json_token_lexer (
  input  logic           clk_i,
  input  logic           rst_ni,
  jtl_in_if.sink         in_i,
  jtl_out_if.source      out_o
);

  logic                          in_vld_q;
  logic [jtl_pkg::CHAR_W-1:0]    char_q;
  logic                          fin_q;
  logic                          fire;
  logic                          room;
  logic [1:0]                    res_cnt;
  logic [1:0]                    push_cnt;
  jtl_pkg::jtl_res_t             res0, res1, head;
  logic                          head_vld;
  logic [jtl_pkg::RES_CNT_W-1:0] fifo_cnt;

  // A held byte is lexed once the queue can take both of its possible results.
  assign fire       = in_vld_q && room;
  assign in_i.ready = !in_vld_q || fire;
  assign push_cnt   = fire ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.text_byte;
      fin_q  <= in_i.final_byte;
    end
  end

  jtl_lex_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .char_i    (char_q),
    .fin_i     (fin_q),
    .res_cnt_o (res_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  jtl_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (out_o.ready),
    .head_o     (head),
    .valid_o    (head_vld),
    .room_o     (room),
    .count_o    (fifo_cnt)
  );

  assign out_o.valid       = head_vld;
  assign out_o.token_kind  = head.token_kind;
  assign out_o.lexeme_char = head.lexeme_char;
  assign out_o.char_valid  = head.char_valid;
  assign out_o.token_done  = head.token_done;
  assign out_o.error_code  = head.error_code;
  assign out_o.run_last    = head.run_last;

  `JTL_ASSERT_ALWAYS(a_fifo_bound, fifo_cnt <= jtl_pkg::RES_CNT_W'(jtl_pkg::RES_DEPTH),
                     "result queue overflow")
  `JTL_ASSERT_IMPLY(a_err_clean, head_vld && (head.error_code != jtl_pkg::ERR_NONE),
                    (head.token_kind == jtl_pkg::KIND_LBRACKET) && !head.char_valid &&
                    !head.token_done && head.run_last,
                    "error result carries token fields")
  `JTL_ASSERT_IMPLY(a_char_zero, head_vld && !head.char_valid, head.lexeme_char == '0,
                    "lexeme byte set without char_valid")
  `JTL_ASSERT_IMPLY(a_two_last, fire && (res_cnt == 2'd2), !res0.run_last && res1.run_last,
                    "run_last misplaced on a two-result byte")

endmodule
